### hdl/wsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared types, constants and helpers for the windowed standard deviation block.
// ----------------------------------------------------------------------------
package wsd_pkg;

  localparam int SAMPLE_BITS    = 24;
  localparam int MEAN_BITS      = 48;
  localparam int MEAN_FRAC      = MEAN_BITS - SAMPLE_BITS;
  localparam int Q4_SHIFT       = MEAN_FRAC - 4;
  localparam int FIX_BITS       = MEAN_BITS + 1;
  localparam int WIDE_BITS      = MEAN_BITS + 4;
  localparam int CNT_BITS       = 13;
  localparam int STD_BITS       = 32;
  localparam int SUM_BITS       = 64;
  localparam int DIV_BITS       = 64;
  localparam int OPND_BITS      = 32;
  localparam int VAR_SAT_BIT    = 52;
  localparam int ROOT_SHIFT     = 12;
  localparam int MAX_WINDOW_DEF = 4096;

  localparam logic [CNT_BITS-1:0] WIN_RESET = CNT_BITS'(1000);
  localparam logic signed [WIDE_BITS-1:0] OPND_LIM = WIDE_BITS'(64'h7FFF_FFFF);

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_value;
    logic                          sample_missing;
  } wsd_in_t;

  typedef struct packed {
    logic [STD_BITS-1:0] std_dev;
    logic                result_valid;
    logic [CNT_BITS-1:0] present_count;
  } wsd_out_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_ADD,
    OP_REMOVE,
    OP_SWAP,
    OP_CLEAR
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_MEAN_DIV,
    S_MEAN,
    S_OPND,
    S_MUL,
    S_SUM,
    S_VAR,
    S_VAR_DIV,
    S_ROOT,
    S_SQRT,
    S_OUT
  } state_t;

  typedef struct packed {
    logic accept;
    logic setup;
    logic mean_upd;
    logic opnd;
    logic mul;
    logic sum_upd;
    logic var_start;
    logic root_start;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic div_done;
    logic sqrt_done;
    logic few;
    logic sat;
  } status_t;

  // truncate toward zero to Q4, then saturate to the operand range
  function automatic logic signed [OPND_BITS-1:0] q4_opnd(
    input logic signed [WIDE_BITS-1:0] v
  );
    logic signed [WIDE_BITS-1:0] b;
    logic signed [WIDE_BITS-1:0] t;
    b = v[WIDE_BITS-1] ? v + WIDE_BITS'((64'd1 << Q4_SHIFT) - 64'd1) : v;
    t = b >>> Q4_SHIFT;
    if (t > OPND_LIM) begin
      t = OPND_LIM;
    end else if (t < -OPND_LIM) begin
      t = -OPND_LIM;
    end
    return t[OPND_BITS-1:0];
  endfunction

endpackage

### hdl/wsd_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_div
// Radix-2 restoring divider, one quotient bit per cycle, unsigned operands.
// ----------------------------------------------------------------------------
module wsd_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [wsd_pkg::DIV_BITS-1:0]  dividend,
  input  logic [wsd_pkg::CNT_BITS-1:0]  divisor,
  output logic                          done,
  output logic [wsd_pkg::DIV_BITS-1:0]  quotient
);

  localparam int CW = $clog2(wsd_pkg::DIV_BITS + 1);

  logic                          busy;
  logic [CW-1:0]                 cnt;
  logic [wsd_pkg::CNT_BITS-1:0]  dvs;
  logic [wsd_pkg::CNT_BITS-1:0]  rem;
  logic [wsd_pkg::CNT_BITS:0]    rem_sh;
  logic [wsd_pkg::CNT_BITS:0]    rem_sub;
  logic                          fit;

  assign rem_sh  = {rem, quotient[wsd_pkg::DIV_BITS-1]};
  assign rem_sub = rem_sh - {1'b0, dvs};
  assign fit     = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(wsd_pkg::DIV_BITS);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      dvs      <= divisor;
      rem      <= '0;
    end else if (busy) begin
      quotient <= {quotient[wsd_pkg::DIV_BITS-2:0], fit};
      rem      <= fit ? rem_sub[wsd_pkg::CNT_BITS-1:0] : rem_sh[wsd_pkg::CNT_BITS-1:0];
    end
  end

endmodule

### hdl/wsd_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_sqrt
// Bit-pair integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module wsd_sqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [wsd_pkg::SUM_BITS-1:0]  radicand,
  output logic                          done,
  output logic [wsd_pkg::STD_BITS-1:0]  root
);

  localparam int N  = wsd_pkg::SUM_BITS;
  localparam int CW = $clog2(N / 2 + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [N-1:0]  v;
  logic [N-1:0]  res;
  logic [N-1:0]  bitv;
  logic [N-1:0]  trial;

  assign trial = res + bitv;
  assign root  = res[wsd_pkg::STD_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(N / 2);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v    <= radicand;
      res  <= '0;
      bitv <= N'(1) << (N - 2);
    end else if (busy) begin
      if (v >= trial) begin
        v   <= v - trial;
        res <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
      bitv <= bitv >> 2;
    end
  end

endmodule

### hdl/wsd_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_dp
// Datapath: sample history, running mean and sum, divider and square root.
// ----------------------------------------------------------------------------
module wsd_dp #(
  parameter int MAX_WINDOW = wsd_pkg::MAX_WINDOW_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          window_we,
  input  logic [wsd_pkg::CNT_BITS-1:0]  window_wdata,
  input  wsd_pkg::wsd_in_t              sample,
  input  wsd_pkg::cmd_t                 cmd,
  output wsd_pkg::status_t              status,
  output wsd_pkg::wsd_out_t             stat
);

  localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int SB = wsd_pkg::SAMPLE_BITS;
  localparam int MB = wsd_pkg::MEAN_BITS;
  localparam int FB = wsd_pkg::FIX_BITS;
  localparam int WB = wsd_pkg::WIDE_BITS;
  localparam int CB = wsd_pkg::CNT_BITS;
  localparam int HB = SB + 1;
  localparam logic signed [MB+2:0] MEAN_MAX = (MB+3)'((64'd1 << (MB - 1)) - 64'd1);
  localparam logic signed [MB+2:0] MEAN_MIN = -((MB+3)'(64'd1 << (MB - 1)));

  logic [HB-1:0]             mem [MAX_WINDOW];
  logic [HB-1:0]             rd_q;
  logic [CB-1:0]             win;
  logic [CB-1:0]             weff;
  logic [AW-1:0]             wp;
  logic [AW-1:0]             rd_addr;
  logic [CB-1:0]             fill;
  logic [CB-1:0]             present;
  logic signed [MB-1:0]      mean;
  logic signed [MB-1:0]      prev_mean;
  logic [wsd_pkg::SUM_BITS-1:0] sum;
  logic signed [SB-1:0]      x_reg;
  logic                      miss_reg;
  logic                      have_old;
  wsd_pkg::op_t              op_q;
  wsd_pkg::op_t              op_now;
  logic                      qneg;
  logic signed [wsd_pkg::OPND_BITS-1:0] opa;
  logic signed [wsd_pkg::OPND_BITS-1:0] opb;
  logic signed [wsd_pkg::SUM_BITS-1:0]  prod;

  logic                      old_miss;
  logic signed [SB-1:0]      old_val;
  logic signed [FB-1:0]      xs_fix;
  logic signed [FB-1:0]      xo_fix;
  logic signed [FB-1:0]      xv_fix;
  logic signed [FB-1:0]      mean_ext;
  logic signed [HB-1:0]      diff;
  logic signed [HB-1:0]      pair;
  logic signed [FB-1:0]      num;
  logic [FB-1:0]             mag;
  logic [CB-1:0]             n_setup;
  logic [31:0]               pos32;
  logic [AW-1:0]             wp_next;

  logic                      div_start;
  logic [wsd_pkg::DIV_BITS-1:0] div_dividend;
  logic [CB-1:0]             div_divisor;
  logic                      div_done;
  logic [wsd_pkg::DIV_BITS-1:0] quot;
  logic                      sqrt_done;
  logic [wsd_pkg::STD_BITS-1:0] root;

  logic signed [MB+2:0]      qs;
  logic signed [MB+2:0]      msum;
  logic signed [MB-1:0]      mean_next;
  logic signed [WB-1:0]      dd;
  logic signed [WB-1:0]      ee;
  logic signed [WB-1:0]      ss;
  logic signed [wsd_pkg::SUM_BITS-1:0] p16;
  logic signed [wsd_pkg::SUM_BITS-1:0] inc;
  logic signed [wsd_pkg::SUM_BITS:0]   sacc;
  logic [wsd_pkg::SUM_BITS-1:0]        sum_next;

  always_comb begin
    weff = win;
    if (win < CB'(2)) begin
      weff = CB'(2);
    end else if (32'(win) > 32'(MAX_WINDOW)) begin
      weff = CB'(MAX_WINDOW);
    end
    pos32 = 32'(wp) + 32'(MAX_WINDOW) - 32'(weff);
    if (pos32 >= 32'(MAX_WINDOW)) begin
      pos32 = pos32 - 32'(MAX_WINDOW);
    end
    rd_addr = pos32[AW-1:0];
    wp_next = (wp == AW'(MAX_WINDOW - 1)) ? '0 : wp + AW'(1);
  end

  assign old_miss = rd_q[HB-1];
  assign old_val  = signed'(rd_q[SB-1:0]);
  assign xs_fix   = {x_reg[SB-1], x_reg, {wsd_pkg::MEAN_FRAC{1'b0}}};
  assign xo_fix   = {old_val[SB-1], old_val, {wsd_pkg::MEAN_FRAC{1'b0}}};
  assign mean_ext = {mean[MB-1], mean};
  assign diff     = HB'(x_reg) - HB'(old_val);
  assign pair     = HB'(x_reg) + HB'(old_val);

  always_comb begin
    op_now = wsd_pkg::OP_NONE;
    if (!miss_reg) begin
      op_now = (have_old && !old_miss) ? wsd_pkg::OP_SWAP : wsd_pkg::OP_ADD;
    end else if (have_old && !old_miss) begin
      if (present == CB'(1)) begin
        op_now = wsd_pkg::OP_CLEAR;
      end else if (present != '0) begin
        op_now = wsd_pkg::OP_REMOVE;
      end
    end
  end

  always_comb begin
    unique case (op_now)
      wsd_pkg::OP_ADD: begin
        num     = xs_fix - mean_ext;
        n_setup = present + CB'(1);
      end
      wsd_pkg::OP_REMOVE: begin
        num     = xo_fix - mean_ext;
        n_setup = present - CB'(1);
      end
      wsd_pkg::OP_SWAP: begin
        num     = {diff, {wsd_pkg::MEAN_FRAC{1'b0}}};
        n_setup = present;
      end
      default: begin
        num     = '0;
        n_setup = present;
      end
    endcase
    mag = num[FB-1] ? FB'(-num) : FB'(num);
  end

  always_comb begin
    div_start    = 1'b0;
    div_dividend = wsd_pkg::DIV_BITS'(mag);
    div_divisor  = n_setup;
    if (cmd.setup && (op_now == wsd_pkg::OP_ADD || op_now == wsd_pkg::OP_REMOVE ||
                      op_now == wsd_pkg::OP_SWAP)) begin
      div_start = 1'b1;
    end
    if (cmd.var_start) begin
      div_start    = !status.few;
      div_dividend = sum;
      div_divisor  = present - CB'(1);
    end
  end

  wsd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (quot)
  );

  wsd_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.root_start && !status.sat),
    .radicand ({quot[wsd_pkg::VAR_SAT_BIT-1:0], {wsd_pkg::ROOT_SHIFT{1'b0}}}),
    .done     (sqrt_done),
    .root     (root)
  );

  always_comb begin
    status.op        = op_now;
    status.div_done  = div_done;
    status.sqrt_done = sqrt_done;
    status.few       = present < CB'(2);
    status.sat       = |quot[wsd_pkg::DIV_BITS-1:wsd_pkg::VAR_SAT_BIT];
  end

  always_comb begin
    qs = qneg ? -(MB+3)'({1'b0, quot[FB-1:0]}) : (MB+3)'({1'b0, quot[FB-1:0]});
    msum = (MB+3)'(mean) + qs;
    if (msum > MEAN_MAX) begin
      mean_next = MEAN_MAX[MB-1:0];
    end else if (msum < MEAN_MIN) begin
      mean_next = MEAN_MIN[MB-1:0];
    end else begin
      mean_next = msum[MB-1:0];
    end
  end

  always_comb begin
    xv_fix = (op_q == wsd_pkg::OP_REMOVE) ? xo_fix : xs_fix;
    dd     = WB'(xv_fix) - WB'(prev_mean);
    ee     = WB'(xv_fix) - WB'(mean);
    ss     = WB'(signed'({pair, {wsd_pkg::MEAN_FRAC{1'b0}}})) - WB'(prev_mean) - WB'(mean);
  end

  always_comb begin
    p16 = (prod[wsd_pkg::SUM_BITS-1] ? prod + 64'sd15 : prod) >>> 4;
    unique case (op_q)
      wsd_pkg::OP_SWAP:   inc = prod;
      wsd_pkg::OP_REMOVE: inc = -p16;
      default:            inc = p16;
    endcase
    sacc = signed'({1'b0, sum}) + (wsd_pkg::SUM_BITS+1)'(inc);
    if (sacc[wsd_pkg::SUM_BITS]) begin
      sum_next = '0;
    end else if (sacc[wsd_pkg::SUM_BITS-1]) begin
      sum_next = {1'b0, {(wsd_pkg::SUM_BITS-1){1'b1}}};
    end else begin
      sum_next = sacc[wsd_pkg::SUM_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mem[wp] <= {sample.sample_missing, sample.sample_value};
      rd_q    <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win     <= wsd_pkg::WIN_RESET;
      wp      <= '0;
      fill    <= '0;
      present <= '0;
      mean    <= '0;
      sum     <= '0;
    end else if (window_we) begin
      win     <= window_wdata;
      wp      <= '0;
      fill    <= '0;
      present <= '0;
      mean    <= '0;
      sum     <= '0;
    end else begin
      if (cmd.accept) begin
        wp <= wp_next;
        if (fill < weff) begin
          fill <= fill + CB'(1);
        end
      end
      if (cmd.setup) begin
        if (op_now == wsd_pkg::OP_CLEAR) begin
          present <= '0;
          mean    <= '0;
          sum     <= '0;
        end else begin
          present <= n_setup;
        end
      end
      if (cmd.mean_upd) begin
        mean <= mean_next;
      end
      if (cmd.sum_upd) begin
        sum <= sum_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      x_reg    <= sample.sample_value;
      miss_reg <= sample.sample_missing;
      have_old <= fill >= weff;
    end
    if (cmd.setup) begin
      op_q      <= op_now;
      qneg      <= num[FB-1] ^ (op_now == wsd_pkg::OP_REMOVE);
      prev_mean <= mean;
    end
    if (cmd.opnd) begin
      if (op_q == wsd_pkg::OP_SWAP) begin
        opa <= wsd_pkg::OPND_BITS'(diff);
        opb <= wsd_pkg::q4_opnd(ss);
      end else begin
        opa <= wsd_pkg::q4_opnd(dd);
        opb <= wsd_pkg::q4_opnd(ee);
      end
    end
    if (cmd.mul) begin
      prod <= opa * opb;
    end
    if (cmd.load_out) begin
      stat.std_dev       <= status.few ? '0 : (status.sat ? '1 : root);
      stat.result_valid  <= !status.few;
      stat.present_count <= present;
    end
  end

endmodule

### hdl/wsd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_ctrl
// Sequencer for one beat: history access, mean and sum update, deviation.
// ----------------------------------------------------------------------------
module wsd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              sample_valid,
  output logic              sample_ready,
  output logic              stat_valid,
  input  logic              stat_ready,
  input  wsd_pkg::status_t  status,
  output wsd_pkg::cmd_t     cmd
);

  wsd_pkg::state_t state;
  wsd_pkg::state_t state_next;
  logic            load;

  assign load         = (state == wsd_pkg::S_OUT) && (!stat_valid || stat_ready);
  assign sample_ready = state == wsd_pkg::S_IDLE;

  always_comb begin
    state_next = state;
    unique case (state)
      wsd_pkg::S_IDLE:     if (sample_valid) state_next = wsd_pkg::S_READ;
      wsd_pkg::S_READ: begin
        if (status.op == wsd_pkg::OP_NONE || status.op == wsd_pkg::OP_CLEAR) begin
          state_next = wsd_pkg::S_VAR;
        end else begin
          state_next = wsd_pkg::S_MEAN_DIV;
        end
      end
      wsd_pkg::S_MEAN_DIV: if (status.div_done) state_next = wsd_pkg::S_MEAN;
      wsd_pkg::S_MEAN:     state_next = wsd_pkg::S_OPND;
      wsd_pkg::S_OPND:     state_next = wsd_pkg::S_MUL;
      wsd_pkg::S_MUL:      state_next = wsd_pkg::S_SUM;
      wsd_pkg::S_SUM:      state_next = wsd_pkg::S_VAR;
      wsd_pkg::S_VAR:      state_next = status.few ? wsd_pkg::S_OUT : wsd_pkg::S_VAR_DIV;
      wsd_pkg::S_VAR_DIV:  if (status.div_done) state_next = wsd_pkg::S_ROOT;
      wsd_pkg::S_ROOT:     state_next = status.sat ? wsd_pkg::S_OUT : wsd_pkg::S_SQRT;
      wsd_pkg::S_SQRT:     if (status.sqrt_done) state_next = wsd_pkg::S_OUT;
      wsd_pkg::S_OUT:      if (load) state_next = wsd_pkg::S_IDLE;
      default:             state_next = wsd_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.accept     = (state == wsd_pkg::S_IDLE) && sample_valid;
    cmd.setup      = state == wsd_pkg::S_READ;
    cmd.mean_upd   = (state == wsd_pkg::S_MEAN);
    cmd.opnd       = state == wsd_pkg::S_OPND;
    cmd.mul        = state == wsd_pkg::S_MUL;
    cmd.sum_upd    = state == wsd_pkg::S_SUM;
    cmd.var_start  = state == wsd_pkg::S_VAR;
    cmd.root_start = state == wsd_pkg::S_ROOT;
    cmd.load_out   = load;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= wsd_pkg::S_IDLE;
      stat_valid <= 1'b0;
    end else begin
      state      <= state_next;
      stat_valid <= load || (stat_valid && !stat_ready);
    end
  end

endmodule

### hdl/windowed_std_dev_skip_missing_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_std_dev_skip_missing_core
// Sliding-window sample standard deviation over present samples, Q8 output.
// ----------------------------------------------------------------------------
//  channel | signals                                 | direction
//  sample  | sample_valid, sample_ready, sample      | in
//  stat    | stat_valid, stat_ready, stat            | out
//  window  | window_we, window_wdata                 | in, write only
//
//  One beat runs two passes of the 64-step radix-2 divider
//  (mean update, then variance) and 32 steps of the square root unit.
//  Beats with no mean change skip the first divide.
//  Reset and any window write clear the history pointer, counts, mean and sum.
//  A finished result waits in the output register while the next beat runs.
// ----------------------------------------------------------------------------
module windowed_std_dev_skip_missing_core #(
  parameter int MAX_WINDOW = wsd_pkg::MAX_WINDOW_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          sample_valid,
  output logic                          sample_ready,
  input  wsd_pkg::wsd_in_t              sample,
  output logic                          stat_valid,
  input  logic                          stat_ready,
  output wsd_pkg::wsd_out_t             stat,
  input  logic                          window_we,
  input  logic [wsd_pkg::CNT_BITS-1:0]  window_wdata
);

  wsd_pkg::cmd_t    cmd;
  wsd_pkg::status_t status;

  wsd_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .stat_valid   (stat_valid),
    .stat_ready   (stat_ready),
    .status       (status),
    .cmd          (cmd)
  );

  wsd_dp #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .window_we    (window_we),
    .window_wdata (window_wdata),
    .sample       (sample),
    .cmd          (cmd),
    .status       (status),
    .stat         (stat)
  );

endmodule
